// File: rtl/core/tch_pkg.sv
// Shared types, widths and constants of the tilt-compensated heading unit.
package tch_pkg;

    // fraction bits of the rotation matrix entries (Q1.14)
    localparam int MATRIX_FRAC_BITS = 14;

    localparam int IN_W   = 16;   // every input field
    localparam int OUT_W  = 16;   // heading, Q3.13
    localparam int HX_W   = 48;   // tilt-corrected X, any input bit pattern
    localparam int HY_W   = 33;   // tilt-corrected Y, any input bit pattern
    localparam int CW     = 42;   // CORDIC x/y datapath, normalized plus gain
    localparam int ANG_W  = 32;   // angle accumulator, Q29 radians
    localparam int LZ_W   = $clog2(HX_W);
    localparam int GROUPS = HX_W / 8;
    localparam int GRP_W  = $clog2(GROUPS);
    localparam int NORM_MSB = 38; // larger magnitude lands in [2^38, 2^39)
    localparam int ATAN_LEN = 24;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q29   = 32'sd843314857;
    localparam logic signed [OUT_W-1:0] HEADING_LIMIT = 16'sd25805;

    // tilt-corrected vector: x = X, y = -Y
    typedef struct packed {
        logic signed [HX_W-1:0] x;
        logic signed [HY_W-1:0] y;
    } hvec_t;

    // word handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;   // input vector was zero
    } rot_t;

    // atan(2^-i) in Q29, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q29(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = 32'sd421657428;
            1:       r = 32'sd248918915;
            2:       r = 32'sd131521918;
            3:       r = 32'sd66762579;
            4:       r = 32'sd33510843;
            5:       r = 32'sd16771758;
            6:       r = 32'sd8387925;
            7:       r = 32'sd4194219;
            8:       r = 32'sd2097141;
            9:       r = 32'sd1048575;
            10:      r = 32'sd524288;
            11:      r = 32'sd262144;
            12:      r = 32'sd131072;
            13:      r = 32'sd65536;
            14:      r = 32'sd32768;
            15:      r = 32'sd16384;
            16:      r = 32'sd8192;
            17:      r = 32'sd4096;
            18:      r = 32'sd2048;
            19:      r = 32'sd1024;
            20:      r = 32'sd512;
            21:      r = 32'sd256;
            22:      r = 32'sd128;
            23:      r = 32'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/tch_front.sv
// Five-stage pipeline forming the tilt-corrected horizontal field vector.
module tch_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [tch_pkg::IN_W-1:0]     mag_x,
    input  logic signed [tch_pkg::IN_W-1:0]     mag_y,
    input  logic signed [tch_pkg::IN_W-1:0]     mag_z,
    input  logic signed [tch_pkg::IN_W-1:0]     row_c_x,
    input  logic signed [tch_pkg::IN_W-1:0]     row_c_y,
    input  logic signed [tch_pkg::IN_W-1:0]     row_c_z,
    output logic                                out_valid,
    output tch_pkg::hvec_t                      out_vec
);
    import tch_pkg::*;

    localparam int PW    = 2 * IN_W;
    localparam int Q1_W  = PW + IN_W;
    localparam int Q2_W  = HY_W + IN_W;
    localparam int LOW_W = Q2_W + 1;
    localparam logic signed [LOW_W-1:0] ROUND_HALF =
        LOW_W'(1) <<< (MATRIX_FRAC_BITS - 1);

    logic [4:0] vld_reg, vld_next;

    // stage 1: products
    logic signed [PW-1:0]   pxx_reg, pycz_reg, pzcy_reg, pycy_reg, pzcz_reg;
    logic signed [PW-1:0]   pxx_next, pycz_next, pzcy_next, pycy_next, pzcz_next;
    logic signed [IN_W-1:0] fx1_reg, cx1_reg;
    // stage 2: -Y and the dot term
    logic signed [PW-1:0]   pxx2_reg;
    logic signed [IN_W-1:0] fx2_reg, cx2_reg;
    logic signed [HY_W-1:0] ny2_reg, dot2_reg, ny2_next, dot2_next;
    // stage 3: second products
    logic signed [Q1_W-1:0] q1_reg, q1_next;
    logic signed [Q2_W-1:0] q2_reg, q2_next;
    logic signed [IN_W-1:0] fx3_reg;
    logic signed [HY_W-1:0] ny3_reg;
    // stage 4: correction term with rounding bias
    logic signed [LOW_W-1:0] low4_reg, low4_next;
    logic signed [IN_W-1:0]  fx4_reg;
    logic signed [HY_W-1:0]  ny4_reg;
    // stage 5: X
    logic signed [HX_W-1:0] hx5_reg, hx5_next;
    logic signed [HY_W-1:0] ny5_reg;

    always_comb begin
        vld_next  = {vld_reg[3:0], in_valid};
        pxx_next  = mag_x * row_c_x;
        pycz_next = mag_y * row_c_z;
        pzcy_next = mag_z * row_c_y;
        pycy_next = mag_y * row_c_y;
        pzcz_next = mag_z * row_c_z;
        ny2_next  = HY_W'(pzcy_reg) - HY_W'(pycz_reg);
        dot2_next = HY_W'(pycy_reg) + HY_W'(pzcz_reg);
        q1_next   = pxx2_reg * cx2_reg;
        q2_next   = dot2_reg * cx2_reg;
        low4_next = LOW_W'(q1_reg) + LOW_W'(q2_reg) + ROUND_HALF;
        hx5_next  = (HX_W'(fx4_reg) <<< MATRIX_FRAC_BITS)
                  - HX_W'(low4_reg >>> MATRIX_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg  <= pxx_next;
            pycz_reg <= pycz_next;
            pzcy_reg <= pzcy_next;
            pycy_reg <= pycy_next;
            pzcz_reg <= pzcz_next;
            fx1_reg  <= mag_x;
            cx1_reg  <= row_c_x;
            pxx2_reg <= pxx_reg;
            fx2_reg  <= fx1_reg;
            cx2_reg  <= cx1_reg;
            ny2_reg  <= ny2_next;
            dot2_reg <= dot2_next;
            q1_reg   <= q1_next;
            q2_reg   <= q2_next;
            fx3_reg  <= fx2_reg;
            ny3_reg  <= ny2_reg;
            low4_reg <= low4_next;
            fx4_reg  <= fx3_reg;
            ny4_reg  <= ny3_reg;
            hx5_reg  <= hx5_next;
            ny5_reg  <= ny4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_vec   = '{x: hx5_reg, y: ny5_reg};

endmodule

// File: rtl/core/tch_norm.sv
// Quadrant pre-rotation and block normalization ahead of the CORDIC cells.
module tch_norm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tch_pkg::hvec_t  in_vec,
    output logic            out_valid,
    output tch_pkg::rot_t   out_rot
);
    import tch_pkg::*;

    logic [5:0] vld_reg, vld_next;

    // stage 1: pre-rotation into the right half plane
    logic signed [HX_W-1:0]  x1_reg, y1_reg, x1_next, y1_next, ye;
    logic signed [ANG_W-1:0] z1_reg, z1_next;
    // stage 2: |y|
    logic signed [HX_W-1:0]  x2_reg, y2_reg;
    logic signed [ANG_W-1:0] z2_reg;
    logic [HX_W-1:0]         ay2_reg, ay2_next;
    // stage 3: larger magnitude
    logic signed [HX_W-1:0]  x3_reg, y3_reg;
    logic signed [ANG_W-1:0] z3_reg;
    logic [HX_W-1:0]         m3_reg, m3_next;
    // stage 4: per-byte leading one
    logic signed [HX_W-1:0]  x4_reg, y4_reg;
    logic signed [ANG_W-1:0] z4_reg;
    logic [GROUPS-1:0]       nz4_reg, nz4_next;
    logic [2:0]              pos4_reg [GROUPS];
    logic [2:0]              pos4_next [GROUPS];
    // stage 5: shift amount
    logic signed [HX_W-1:0]  x5_reg, y5_reg;
    logic signed [ANG_W-1:0] z5_reg;
    logic                    lsh5_reg, lsh5_next, zero5_reg, zero5_next;
    logic [LZ_W-1:0]         amt5_reg, amt5_next, msb_pos;
    // stage 6: normalized vector
    tch_pkg::rot_t           rot6_reg, rot6_next;
    logic signed [HX_W-1:0]  xs, ys;

    always_comb begin
        vld_next = {vld_reg[4:0], in_valid};

        ye = HX_W'(in_vec.y);
        if (in_vec.x[HX_W-1]) begin
            if (!ye[HX_W-1] && (ye != '0)) begin
                x1_next = ye;
                y1_next = -in_vec.x;
                z1_next = HALF_PI_Q29;
            end else begin
                x1_next = -ye;
                y1_next = in_vec.x;
                z1_next = -HALF_PI_Q29;
            end
        end else begin
            x1_next = in_vec.x;
            y1_next = ye;
            z1_next = '0;
        end

        ay2_next = y1_reg[HX_W-1] ? $unsigned(-y1_reg) : $unsigned(y1_reg);

        // x is never negative after pre-rotation
        m3_next = ($unsigned(x2_reg) > ay2_reg) ? $unsigned(x2_reg) : ay2_reg;

        for (int g = 0; g < GROUPS; g++) begin
            nz4_next[g]  = |m3_reg[g*8 +: 8];
            pos4_next[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (m3_reg[g*8 + b]) begin
                    pos4_next[g] = 3'(b);
                end
            end
        end

        msb_pos = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (nz4_reg[g]) begin
                msb_pos = LZ_W'({GRP_W'(g), pos4_reg[g]});
            end
        end
        zero5_next = !(|nz4_reg);
        lsh5_next  = msb_pos < LZ_W'(NORM_MSB);
        amt5_next  = lsh5_next ? LZ_W'(NORM_MSB) - msb_pos : msb_pos - LZ_W'(NORM_MSB);

        // right shifts floor, matching repeated halving
        xs = lsh5_reg ? (x5_reg <<< amt5_reg) : (x5_reg >>> amt5_reg);
        ys = lsh5_reg ? (y5_reg <<< amt5_reg) : (y5_reg >>> amt5_reg);
        rot6_next = '{x: CW'(xs), y: CW'(ys), z: z5_reg, zero: zero5_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            z1_reg    <= z1_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            ay2_reg   <= ay2_next;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            m3_reg    <= m3_next;
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
            z4_reg    <= z3_reg;
            nz4_reg   <= nz4_next;
            pos4_reg  <= pos4_next;
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            z5_reg    <= z4_reg;
            lsh5_reg  <= lsh5_next;
            amt5_reg  <= amt5_next;
            zero5_reg <= zero5_next;
            rot6_reg  <= rot6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_rot   = rot6_reg;

endmodule

// File: rtl/core/tch_cell.sv
// One vectoring CORDIC micro-rotation, registered.
module tch_cell #(
    parameter int STAGE = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  tch_pkg::rot_t  in_rot,
    output logic           out_valid,
    output tch_pkg::rot_t  out_rot
);
    import tch_pkg::*;

    localparam logic signed [ANG_W-1:0] STEP_ANG = atan_q29(STAGE);

    logic                  vld_reg;
    tch_pkg::rot_t         rot_reg, rot_next;
    logic signed [CW-1:0]  xs, ys;

    always_comb begin
        xs       = in_rot.x >>> STAGE;
        ys       = in_rot.y >>> STAGE;
        rot_next = in_rot;
        if (!in_rot.y[CW-1] && (in_rot.y != '0)) begin
            rot_next.x = in_rot.x + ys;
            rot_next.y = in_rot.y - xs;
            rot_next.z = in_rot.z + STEP_ANG;
        end else begin
            rot_next.x = in_rot.x - ys;
            rot_next.y = in_rot.y + xs;
            rot_next.z = in_rot.z - STEP_ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_rot   = rot_reg;

endmodule

// File: rtl/core/tilt_compensated_heading_unit.sv
// Top level of the tilt-compensated heading unit: front end, normalizer, CORDIC chain, output.
//
// Takes one word per cycle while the pipe is not stalled, each holding a magnetometer sample
// and the third row of the attitude matrix (Q1.14), and returns one heading word per input:
// atan2(-Y, X) in radians, Q3.13, clamped to +-3.15, where Y = my*cz - mz*cy and
// X = mx*(1 - cx*cx) - cx*(my*cy + mz*cz). The unit keeps no state between words.
// Throughput is one word per clock while the skid entry is empty. The path runs through 5
// multiply/add stages, 6 normalization stages, one cell per CORDIC iteration and one output
// register. All stages move together on one enable driven from a registered
// skid-full flag, so input and output sides are decoupled by a two-entry output
// buffer: the unit keeps accepting while one finished heading waits downstream.
// A zero field vector gives heading 0.

module tilt_compensated_heading_unit #(
    parameter int CORDIC_STAGES = 14     // 8 to 24 micro-rotations
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] mag_x, [31:16] mag_y, [47:32] mag_z,
    // [63:48] row_c_x, [79:64] row_c_y, [95:80] row_c_z
    input  logic [95:0]  s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] heading
    output logic [15:0]  m_axis_tdata
);
    import tch_pkg::*;

    // Q29 angle -> Q13 heading: drop 16 bits, round half up
    localparam int DROP = 16;
    localparam logic signed [ANG_W-1:0] ROUND_BIAS = ANG_W'(1) <<< (DROP - 1);

    // input fields
    logic signed [IN_W-1:0] mag_x, mag_y, mag_z, row_c_x, row_c_y, row_c_z;

    // shared pipeline enable
    logic pipe_en;

    // front end -> normalizer
    logic           front_vld;
    tch_pkg::hvec_t front_vec;

    // normalizer and cells, one slot per link of the chain
    logic           chain_vld [CORDIC_STAGES+1];
    tch_pkg::rot_t  chain_rot [CORDIC_STAGES+1];

    // output side
    tch_pkg::rot_t           last_rot;
    logic                    head_vld;
    logic signed [ANG_W-1:0] z_rnd;
    logic signed [OUT_W-1:0] h_raw, heading_c;

    logic                    out_vld_reg, out_vld_next;
    logic                    skid_vld_reg, skid_vld_next;
    logic signed [OUT_W-1:0] out_reg, out_next, skid_reg, skid_next;

    assign mag_x   = s_axis_tdata[15:0];
    assign mag_y   = s_axis_tdata[31:16];
    assign mag_z   = s_axis_tdata[47:32];
    assign row_c_x = s_axis_tdata[63:48];
    assign row_c_y = s_axis_tdata[79:64];
    assign row_c_z = s_axis_tdata[95:80];

    // The whole pipe stalls only while the skid entry holds a word.
    assign pipe_en       = !skid_vld_reg;
    assign s_axis_tready = pipe_en;

    tch_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_axis_tvalid),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .mag_z     (mag_z),
        .row_c_x   (row_c_x),
        .row_c_y   (row_c_y),
        .row_c_z   (row_c_z),
        .out_valid (front_vld),
        .out_vec   (front_vec)
    );

    // pre-rotation to the right half plane, then scale so the larger
    // magnitude sits in [2^38, 2^39)
    tch_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_vld),
        .in_vec    (front_vec),
        .out_valid (chain_vld[0]),
        .out_rot   (chain_rot[0])
    );

    // chain of micro-rotation cells; cell i shifts by i and uses atan(2^-i)
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        tch_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_vld[i]),
            .in_rot    (chain_rot[i]),
            .out_valid (chain_vld[i+1]),
            .out_rot   (chain_rot[i+1])
        );
    end

    // Round the Q29 angle, clamp, and force zero for a zero field vector.
    always_comb begin
        last_rot  = chain_rot[CORDIC_STAGES];
        head_vld  = chain_vld[CORDIC_STAGES] && pipe_en;
        z_rnd     = last_rot.z + ROUND_BIAS;
        h_raw     = z_rnd[ANG_W-1:DROP];
        heading_c = h_raw;
        if (h_raw > HEADING_LIMIT) begin
            heading_c = HEADING_LIMIT;
        end
        if (h_raw < -HEADING_LIMIT) begin
            heading_c = -HEADING_LIMIT;
        end
        if (last_rot.zero) begin
            heading_c = '0;
        end
    end

    // Output register plus one skid entry.
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (!out_vld_reg || m_axis_tready) begin
            if (skid_vld_reg) begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end else begin
                out_next     = heading_c;
                out_vld_next = head_vld;
            end
        end else if (head_vld) begin
            // downstream stalled: park the word leaving the chain
            skid_next     = heading_c;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// File: sim/tb_tilt_compensated_heading_unit.sv
// Testbench of the tilt-compensated heading unit: random and directed samples against a predictor.
module tb_tilt_compensated_heading_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Micro-rotations in the DUT and in the predictor.
    localparam int ROT_STAGES   = 14;
    localparam int FRAC         = tch_pkg::MATRIX_FRAC_BITS;
    // Nominal pipeline depth of the DUT, used to size the tail wait.
    localparam int LATENCY      = ROT_STAGES + 12;
    // Wait after the last heading word, in case anything stray comes out.
    localparam int TAIL_CYCLES  = 3 * LATENCY;
    // Cycles with no word accepted on either side before giving up. The limit
    // covers the longest sender gap and sink stall, plus the pipeline.
    localparam int QUIET_LIMIT  = 2000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [15:0] mag_x, [31:16] mag_y, [47:32] mag_z,
    // [63:48] row_c_x, [79:64] row_c_y, [95:80] row_c_z
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [15:0] heading
    logic [15:0]  m_axis_tdata;

    // Expected headings, oldest first, one per accepted sample word.
    logic signed [15:0] heading_q[$];
    logic signed [15:0] want_heading;
    int                 mismatches;
    int                 quiet_cycles;

    // Idle knobs: when set, that side inserts random gaps / stalls.
    bit src_idles;
    bit sink_idles;
    int stall_left;

    tilt_compensated_heading_unit #(
        .CORDIC_STAGES(ROT_STAGES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // atan(2^-i) in Q29, nearest.
    function automatic longint arctan_step_q29(input int i);
        longint r;
        case (i)
            0:       r = 421657428;
            1:       r = 248918915;
            2:       r = 131521918;
            3:       r = 66762579;
            4:       r = 33510843;
            5:       r = 16771758;
            6:       r = 8387925;
            7:       r = 4194219;
            8:       r = 2097141;
            9:       r = 1048575;
            10:      r = 524288;
            11:      r = 262144;
            12:      r = 131072;
            13:      r = 65536;
            14:      r = 32768;
            15:      r = 16384;
            16:      r = 8192;
            17:      r = 4096;
            18:      r = 2048;
            19:      r = 1024;
            20:      r = 512;
            21:      r = 256;
            22:      r = 128;
            23:      r = 64;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Vectoring CORDIC angle of (vx, vy), Q29 radians.
    function automatic longint vector_angle_q29(input longint vx, input longint vy);
        longint ang;
        longint tmp;
        longint big;
        longint ax;
        longint ay;
        longint xs;
        longint ys;
        ang = 0;
        // Left half-plane: pre-rotate by a quarter turn.
        if (vx < 0) begin
            tmp = vx;
            if (vy > 0) begin
                vx  = vy;
                vy  = -tmp;
                ang = 843314857;
            end else begin
                vx  = -vy;
                vy  = tmp;
                ang = -843314857;
            end
        end
        ax  = (vx < 0) ? -vx : vx;
        ay  = (vy < 0) ? -vy : vy;
        big = (ax > ay) ? ax : ay;
        if (big == 0)
            return 0;
        // Larger magnitude into [2^38, 2^39); downshift floors.
        while (big < (longint'(1) << 38)) begin
            vx  = vx * 2;
            vy  = vy * 2;
            big = big * 2;
        end
        while (big >= (longint'(1) << 39)) begin
            vx  = vx >>> 1;
            vy  = vy >>> 1;
            big = big >>> 1;
        end
        for (int i = 0; i < ROT_STAGES && i < 24; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy > 0) begin
                vx  = vx + ys;
                vy  = vy - xs;
                ang = ang + arctan_step_q29(i);
            end else begin
                vx  = vx - ys;
                vy  = vy + xs;
                ang = ang - arctan_step_q29(i);
            end
        end
        return ang;
    endfunction

    // Heading (Q3.13) for one sample word as laid out on s_axis_tdata.
    function automatic logic signed [15:0] predict_heading(input logic [95:0] word);
        longint fx;
        longint fy;
        longint fz;
        longint cx;
        longint cy;
        longint cz;
        longint horiz_y;
        longint dot;
        longint tilt_term;
        longint tilt_round;
        longint horiz_x;
        longint ang;
        longint h;
        fx = $signed(word[15:0]);
        fy = $signed(word[31:16]);
        fz = $signed(word[47:32]);
        cx = $signed(word[63:48]);
        cy = $signed(word[79:64]);
        cz = $signed(word[95:80]);
        horiz_y    = fy * cz - fz * cy;
        dot        = fy * cy + fz * cz;
        // 2F fraction bits, rounded half up back to F
        tilt_term  = fx * cx * cx + cx * dot;
        tilt_round = (tilt_term + (longint'(1) << (FRAC - 1))) >>> FRAC;
        horiz_x    = fx * (longint'(1) << FRAC) - tilt_round;
        ang        = vector_angle_q29(horiz_x, -horiz_y);
        // Q29 -> Q13, half up, then clamp to +-3.15
        h = (ang + (longint'(1) << 15)) >>> 16;
        if (h > 25805)
            h = 25805;
        if (h < -25805)
            h = -25805;
        return h[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check each heading word, then record each sample word.
    // A sample passes through the whole registered pipeline before its heading
    // comes out, so the pop never needs the push made at the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (heading_q.size() == 0) begin
                    $error("heading: no word expected, got %0d", $signed(m_axis_tdata));
                    mismatches++;
                end else begin
                    want_heading = heading_q.pop_front();
                    if (m_axis_tdata !== want_heading) begin
                        $error("heading: expected %0d, got %0d",
                               want_heading, $signed(m_axis_tdata));
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                heading_q.push_back(predict_heading(s_axis_tdata));
        end
    end

    // Watchdog: any handshake on either side clears the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // Sink side: tready changes on the falling edge only.
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_idles && $urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 19) == 0)
                        stall_left = $urandom_range(20, 60);
                    else
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one sample word at the falling edge, hold until accepted, then,
    // when src_idles is set, idle for a random gap (garbage on tdata while tvalid is low).
    task automatic send_sample(input int mx, input int my, input int mz,
                               input int cx, input int cy, input int cz);
        int gap;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cz[15:0], cy[15:0], cx[15:0], mz[15:0], my[15:0], mx[15:0]};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        gap = src_idles ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom};
            @(posedge aclk);
        end
    endtask

    // Full-range 16-bit value, shifted down by up to max_shift bits.
    function automatic int rand_mag(input int max_shift);
        logic [31:0]        bits;
        logic signed [15:0] w;
        bits = $urandom;
        w    = bits[15:0];
        return int'(w >>> $urandom_range(0, max_shift));
    endfunction

    // Matrix entry within +-1.0.
    function automatic int rand_row();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Drop tvalid so the last word is not sent again, then drain.
    task automatic wait_for_headings();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (heading_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and matrix entries at and beyond +-1.0.
    task automatic test_field_extremes();
        send_sample( 32767,  32767,  32767,  32767,  32767,  32767);
        send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        send_sample(-32768,  32767, -32768,  32767, -32768,  32767);
        send_sample( 32767, -32768,  32767, -32768,  32767, -32768);
        send_sample( 32767,      0,      0,  16384,      0,      0);
        send_sample( 32767,  32767,      0, -16384,  16384,  16384);
        send_sample(-32768,      0,  32767,      0, -16384, -16384);
        send_sample(  1000,   2000,   3000, -32768,  32767, -32768);
        send_sample(    -1,     -1,     -1,     -1,     -1,     -1);
        send_sample(     1,      1,      1,      1,      1,      1);
    endtask

    // Zero vector, -pi, cardinal headings on a level platform, tiny vectors.
    task automatic test_special_cases();
        send_sample(     0,      0,      0,      0,      0,      0);  // zero vector
        send_sample(     0,      0,      0,  12000,  -5000,   9000);  // zero field, tilted
        send_sample(     0,   5000,      0,      0,      0,      0);  // row all zero
        send_sample( -1000,      0,  777,      0,      0,  16384);  // negative X, zero Y
        send_sample(-32768,      0,      0,      0,      0,  16384);  // -pi at full scale
        send_sample( 20000,      0,      0,      0,      0,  16384);  // north
        send_sample(     0,  20000,      0,      0,      0,  16384);
        send_sample(     0, -20000,      0,      0,      0,  16384);
        send_sample( 20000,  20000,      0,      0,      0,  16384);
        send_sample(     1,      0,      0,      0,      0,  16384);  // deep upshift
        send_sample(     0,      1,      0,      0,      0,      1);
        send_sample(    -1,      1,      0,      0,      0,  16384);
    endtask

    // Level platform, full-range field.
    task automatic test_level_compass(input int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_mag(15), rand_mag(15), rand_mag(15),
                        $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                        $urandom_range(0, 1) ? 16384 : -16384);
    endtask

    // Tilted platform, field of random scale: the bulk of the run.
    task automatic test_tilted_samples(input int n);
        int sh;
        for (int i = 0; i < n; i++) begin
            sh = $urandom_range(0, 1) ? 0 : 15;
            send_sample(rand_mag(sh), rand_mag(sh), rand_mag(sh),
                        rand_row(), rand_row(), rand_row());
        end
    endtask

    // Any bit pattern on every field, matrix beyond +-1.0 included.
    task automatic test_raw_patterns(input int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_mag(0), rand_mag(0), rand_mag(0),
                        rand_mag(0), rand_mag(0), rand_mag(0));
    endtask

    // Field of a few counts: zero vectors and heavy normalization.
    task automatic test_tiny_field(input int n);
        for (int i = 0; i < n; i++)
            send_sample($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                        $urandom_range(0, 8) - 4, rand_row(), rand_row(), rand_row());
    endtask

    // Sender stops mid-stream until every heading has come back.
    task automatic test_drain_pause(input int n);
        test_tilted_samples(n);
        wait_for_headings();
        test_tilted_samples(n);
        wait_for_headings();
    endtask

    // Both sides at full rate.
    task automatic test_back_to_back(input int n);
        src_idles  = 1'b0;
        sink_idles = 1'b0;
        test_raw_patterns(n);
        src_idles  = 1'b1;
        sink_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        src_idles     = 1'b1;
        sink_idles    = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_special_cases();
        test_level_compass(150);
        test_tilted_samples(300);
        test_back_to_back(60);
        test_raw_patterns(200);
        test_drain_pause(40);
        test_tiny_field(100);
        test_tilted_samples(260);

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_for_headings();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && heading_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tch_pkg.sv
rtl/core/tch_front.sv
rtl/core/tch_norm.sv
rtl/core/tch_cell.sv
rtl/core/tilt_compensated_heading_unit.sv
sim/tb_tilt_compensated_heading_unit.sv
